@@ rtl/rcid_pkg.sv @@
// Package for the reference counted id slot table: sizes, status codes,
// result word type, RAM request type and field conversion helpers. No dependencies.
package rcid_pkg;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned ID_BITS    = 32;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ENTRY_W    = ID_BITS + COUNT_BITS;

  // fixed widths of the port fields
  localparam int unsigned REGION_W  = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned HOLDERS_W = 16;
  localparam int unsigned STATUS_W  = 3;

  localparam int unsigned IDX_WIDE = (IDX_BITS > SLOT_W) ? IDX_BITS : SLOT_W;
  localparam int unsigned CNT_WIDE = (COUNT_BITS > HOLDERS_W) ? COUNT_BITS : HOLDERS_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [0:0] {
    CMD_OPEN  = 1'b0,
    CMD_CLOSE = 1'b1
  } rcid_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OPEN_OLD  = 3'd0,
    ST_OPEN_NEW  = 3'd1,
    ST_FULL      = 3'd2,
    ST_HELD      = 3'd3,
    ST_RELEASED  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_BAD_ID    = 3'd6
  } rcid_status_e;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [HOLDERS_W-1:0] holders;
    rcid_status_e         status;
  } rcid_res_t;

  typedef struct packed {
    logic                re;
    logic [IDX_BITS-1:0] raddr;
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    logic [ENTRY_W-1:0]  wdata;
  } rcid_ram_req_t;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_BITS-1:0] idx);
    logic [IDX_WIDE-1:0] w;
    w = IDX_WIDE'(idx);
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [HOLDERS_W-1:0] to_holders(input logic [COUNT_BITS-1:0] cnt);
    logic [CNT_WIDE-1:0] w;
    w = CNT_WIDE'(cnt);
    return w[HOLDERS_W-1:0];
  endfunction

endpackage

@@ rtl/rcid_if.sv @@
// Valid/ready channel interfaces for request and result words.
// Depends on rcid_pkg.
interface rcid_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [rcid_pkg::REGION_W-1:0] region_id;

  modport source (output valid, cmd, region_id, input ready);
  modport sink   (input valid, cmd, region_id, output ready);
endinterface

interface rcid_out_if;
  logic                           valid;
  logic                           ready;
  logic [rcid_pkg::SLOT_W-1:0]    slot;
  logic [rcid_pkg::HOLDERS_W-1:0] holders;
  logic [rcid_pkg::STATUS_W-1:0]  status;

  modport source (output valid, slot, holders, status, input ready);
  modport sink   (input valid, slot, holders, status, output ready);
endinterface

@@ rtl/refcounted_id_slot_table.sv @@
// Top level of the reference counted id slot table: request/result channels,
// output register, slot RAM and scan sequencer.
// Depends on rcid_pkg, rcid_if, rcid_ram and rcid_ctrl.
//
//   channel | dir | word                              | accepted when
//   in_i    | in  | cmd, region_id                    | in_i.valid && in_i.ready
//   out_o   | out | slot, holders, status             | out_o.valid && out_o.ready
//
// A request with a valid id passes from acceptance to its result in the output
// register through a read of each of the 64 slots in the single compare unit,
// the read latency, one update step and one handoff; a zero id skips the scan.
// The occupancy bits clear at reset, so the table is usable right after it.
// A result waiting in the output register does not stop the next request; only
// a second finished result waits in the sequencer until the register frees.
module refcounted_id_slot_table (
  input  logic  clk_i,
  input  logic  rst_ni,
  rcid_in_if.sink    in_i,
  rcid_out_if.source out_o
);

  logic                          ctrl_ready;
  logic                          res_valid;
  rcid_pkg::rcid_res_t           res;
  logic                          res_take;
  rcid_pkg::rcid_ram_req_t       ram_req;
  logic [rcid_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                          out_valid_q;
  rcid_pkg::rcid_res_t           out_res_q;

  assign in_i.ready = ctrl_ready;
  assign res_take   = res_valid && (!out_valid_q || out_o.ready);

  rcid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid && ctrl_ready),
    .cmd_i       (in_i.cmd),
    .region_id_i (in_i.region_id),
    .ready_o     (ctrl_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  rcid_ram #(
    .WIDTH (rcid_pkg::ENTRY_W),
    .DEPTH (rcid_pkg::SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.slot    = out_res_q.slot;
  assign out_o.holders = out_res_q.holders;
  assign out_o.status  = out_res_q.status;

endmodule

@@ rtl/rcid_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rcid_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rcid_ctrl.sv @@
// Sequencer for the slot table: scans all slots through one compare unit,
// then updates at most one slot through one shared increment/decrement adder.
// Depends on rcid_pkg; drives the slot RAM through a request struct.
module rcid_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          cmd_i,
  input  logic [rcid_pkg::REGION_W-1:0] region_id_i,
  output logic                          ready_o,
  output logic                          res_valid_o,
  output rcid_pkg::rcid_res_t           res_o,
  input  logic                          res_take_i,
  output rcid_pkg::rcid_ram_req_t       ram_req_o,
  input  logic [rcid_pkg::ENTRY_W-1:0]  ram_rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [rcid_pkg::IDX_BITS-1:0] LAST_IDX = rcid_pkg::IDX_BITS'(rcid_pkg::SLOTS - 1);

  logic [2:0]                        state_q, state_d;
  logic                              cmd_q, cmd_d;
  logic [rcid_pkg::ID_BITS-1:0]      id_q, id_d;
  logic [rcid_pkg::IDX_BITS-1:0]     addr_q, addr_d;
  logic                              pend_q, pend_d;
  logic [rcid_pkg::IDX_BITS-1:0]     pend_idx_q, pend_idx_d;
  logic                              hit_found_q, hit_found_d;
  logic [rcid_pkg::IDX_BITS-1:0]     hit_idx_q, hit_idx_d;
  logic [rcid_pkg::COUNT_BITS-1:0]   hit_cnt_q, hit_cnt_d;
  logic                              free_found_q, free_found_d;
  logic [rcid_pkg::IDX_BITS-1:0]     free_idx_q, free_idx_d;
  logic [rcid_pkg::SLOTS-1:0]        valid_q, valid_d;
  rcid_pkg::rcid_res_t               res_q, res_d;

  logic [rcid_pkg::ID_BITS-1:0]      start_id;
  logic [rcid_pkg::ID_BITS-1:0]      rd_id;
  logic [rcid_pkg::COUNT_BITS-1:0]   rd_cnt;
  logic                              rd_valid;
  logic                              is_match;
  logic                              is_free;
  logic                              is_open;
  logic                              cnt_stuck;
  logic [rcid_pkg::COUNT_BITS-1:0]   cnt_step;
  logic [rcid_pkg::COUNT_BITS-1:0]   cnt_new;
  rcid_pkg::rcid_ram_req_t           ram_req;

  assign start_id = rcid_pkg::ID_BITS'(region_id_i);
  assign rd_id    = ram_rdata_i[rcid_pkg::COUNT_BITS +: rcid_pkg::ID_BITS];
  assign rd_cnt   = ram_rdata_i[rcid_pkg::COUNT_BITS-1:0];
  assign rd_valid = valid_q[pend_idx_q];
  // shared compare unit, one slot per cycle
  assign is_match = pend_q && rd_valid && (rd_id == id_q);
  assign is_free  = pend_q && !rd_valid;

  // shared adder: +1 for open, -1 for close, held at the saturation bound
  assign is_open   = (cmd_q == rcid_pkg::CMD_OPEN);
  assign cnt_stuck = is_open ? (hit_cnt_q == rcid_pkg::COUNT_MAX) : (hit_cnt_q == '0);
  assign cnt_step  = hit_cnt_q + (is_open ? rcid_pkg::COUNT_BITS'(1) : rcid_pkg::COUNT_MAX);
  assign cnt_new   = cnt_stuck ? hit_cnt_q : cnt_step;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    id_d         = id_q;
    addr_d       = addr_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_cnt_d    = hit_cnt_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    res_d        = res_q;
    ram_req      = '0;

    // result of the read issued last cycle
    if (is_match && !hit_found_q) begin
      hit_found_d = 1'b1;
      hit_idx_d   = pend_idx_q;
      hit_cnt_d   = rd_cnt;
    end
    if (is_free && !free_found_q) begin
      free_found_d = 1'b1;
      free_idx_d   = pend_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d        = cmd_i;
          id_d         = start_id;
          addr_d       = '0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          if (start_id == '0) begin
            res_d   = '{slot: '0, holders: '0, status: rcid_pkg::ST_BAD_ID};
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = addr_q;
        pend_d        = 1'b1;
        pend_idx_d    = addr_q;
        if (addr_q == LAST_IDX) begin
          state_d = S_LAST;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = S_DONE;
        if (is_open) begin
          if (hit_found_q) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = hit_idx_q;
            ram_req.wdata = {id_q, cnt_new};
            res_d = '{slot: rcid_pkg::to_slot(hit_idx_q),
                      holders: rcid_pkg::to_holders(cnt_new),
                      status: rcid_pkg::ST_OPEN_OLD};
          end else if (free_found_q) begin
            ram_req.we          = 1'b1;
            ram_req.waddr       = free_idx_q;
            ram_req.wdata       = {id_q, rcid_pkg::COUNT_BITS'(1)};
            valid_d[free_idx_q] = 1'b1;
            res_d = '{slot: rcid_pkg::to_slot(free_idx_q),
                      holders: rcid_pkg::to_holders(rcid_pkg::COUNT_BITS'(1)),
                      status: rcid_pkg::ST_OPEN_NEW};
          end else begin
            res_d = '{slot: '0, holders: '0, status: rcid_pkg::ST_FULL};
          end
        end else begin
          if (!hit_found_q) begin
            res_d = '{slot: '0, holders: '0, status: rcid_pkg::ST_NOT_FOUND};
          end else if (cnt_new == '0) begin
            valid_d[hit_idx_q] = 1'b0;
            res_d = '{slot: rcid_pkg::to_slot(hit_idx_q), holders: '0,
                      status: rcid_pkg::ST_RELEASED};
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = hit_idx_q;
            ram_req.wdata = {id_q, cnt_new};
            res_d = '{slot: rcid_pkg::to_slot(hit_idx_q),
                      holders: rcid_pkg::to_holders(cnt_new),
                      status: rcid_pkg::ST_HELD};
          end
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_q       <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    addr_q     <= addr_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign ram_req_o   = ram_req;

  a_write_in_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == S_UPDATE))
    else $error("slot RAM written outside the update step");

  a_occupancy_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(valid_q) <= $past($countones(valid_q)) + 1) &&
             ($countones(valid_q) + 1 >= $past($countones(valid_q))))
    else $error("occupancy changed by more than one slot");

  a_new_slot_taken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && is_open && !hit_found_q && free_found_q)
      |=> valid_q[$past(free_idx_q)])
    else $error("claimed slot not marked occupied");

  a_released_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.status == rcid_pkg::ST_RELEASED) |-> (res_q.holders == '0))
    else $error("released slot reports holders");

  a_scan_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_SCAN))
    else $error("compare result pending without a scan read");

endmodule
